// ===== sv/int_to_pow2_radix_ascii_unit_defines.svh =====
// Assertion macros for the int_to_pow2_radix_ascii_unit RTL.
// Used by files that assert; expects i_clk and i_rst_n in scope.
`ifndef INT_TO_POW2_RADIX_ASCII_UNIT_DEFINES_SVH
`define INT_TO_POW2_RADIX_ASCII_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define I2PR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition a at one edge implies condition b at the next edge.
`define I2PR_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== sv/i2pr_pkg.sv =====
// Shared types, character codes and digit lookup for the radix ASCII converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2pr_pkg;

    localparam int DIGIT_W = 5;

    localparam logic [2:0] RADIX_MIN = 3'd1;
    localparam logic [2:0] RADIX_MAX = 3'd5;

    localparam logic [6:0] CHAR_NUL   = 7'h00;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h41;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_BAD_RADIX = 1'b1;

    typedef struct packed {
        logic load;
        logic shift;
    } t_shift_ctl;

    typedef struct packed {
        logic [6:0] out_char;
        logic       status;
        logic       last;
    } t_result;

    function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [6:0] d7;
        d7 = {2'b00, d};
        if (d < 5'd10) begin
            return CHAR_ZERO + d7;
        end
        return CHAR_A + d7 - 7'd10;
    endfunction

endpackage

`default_nettype wire

// ===== sv/i2pr_if.sv =====
// Valid/ready channel interfaces: input items and result characters.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface i2pr_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [2:0]            radix_bits;

    modport source (output valid, output value, output radix_bits, input ready);
    modport sink   (input valid, input value, input radix_bits, output ready);
endinterface

interface i2pr_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       status;
    logic       last;

    modport source (output valid, output out_char, output status, output last, input ready);
    modport sink   (input valid, input out_char, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/i2pr_shift_unit.sv =====
// Digit shift register: holds the aligned magnitude and presents the top digit.
// Depends on i2pr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2pr_shift_unit
    import i2pr_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire t_shift_ctl            i_ctl,
    input  wire logic [VALUE_BITS-1:0] i_mag,
    input  wire logic [2:0]            i_pad,
    input  wire logic [2:0]            i_radix,
    output logic      [DIGIT_W-1:0]    o_digit
);

    // room for up to four pad bits so digit edges line up with the top
    localparam int WW = VALUE_BITS + 4;

    logic [WW-1:0] r_work;
    logic [2:0]    r_radix;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_work  <= {4'b0000, i_mag} << i_pad;
            r_radix <= i_radix;
        end else if (i_ctl.shift) begin
            r_work <= r_work << r_radix;
        end
    end

    assign o_digit = r_work[WW-1 -: DIGIT_W] >> (RADIX_MAX - r_radix);

endmodule

`default_nettype wire

// ===== sv/i2pr_out_stage.sv =====
// Result output register on the character channel.
// Depends on i2pr_pkg and i2pr_if.
`timescale 1ns / 1ps
`default_nettype none

module i2pr_out_stage
    import i2pr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_free,
    i2pr_out_if.source   o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_char = r_res.out_char;
    assign o_out.status   = r_res.status;
    assign o_out.last     = r_res.last;

endmodule

`default_nettype wire

// ===== sv/int_to_pow2_radix_ascii_unit.sv =====
// Top level: signed integer to ASCII in base 2^r, one character per transfer.
// Depends on i2pr_pkg, i2pr_if, i2pr_shift_unit, i2pr_out_stage and the defines header.
//
//  channel  dir  transfer when        payload
//  i_in     in   valid & ready        value[VALUE_BITS-1:0], radix_bits[2:0]
//  o_out    out  valid & ready        out_char[6:0], status, last
//
// An item is accepted in S_IDLE, passes S_SIGN if negative, and then the sequencer
// walks one digit position per cycle through the shift unit, leading zeros too, unless stalled.
// A bad radix goes through S_ERR. The next item is taken the cycle after the last push.
// Synchronous active-low reset clears the sequencer and the output valid.
// A stalled output holds the sequencer on emitting steps; skips still advance.
`timescale 1ns / 1ps
`default_nettype none
`include "int_to_pow2_radix_ascii_unit_defines.svh"

module int_to_pow2_radix_ascii_unit
    import i2pr_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    i2pr_in_if.sink    i_in,
    i2pr_out_if.source o_out
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    localparam int ND_1 = VALUE_BITS;
    localparam int ND_2 = (VALUE_BITS + 1) / 2;
    localparam int ND_3 = (VALUE_BITS + 2) / 3;
    localparam int ND_4 = (VALUE_BITS + 3) / 4;
    localparam int ND_5 = (VALUE_BITS + 4) / 5;

    localparam int PAD_1 = VALUE_BITS + 4 - ND_1;
    localparam int PAD_2 = VALUE_BITS + 4 - ND_2 * 2;
    localparam int PAD_3 = VALUE_BITS + 4 - ND_3 * 3;
    localparam int PAD_4 = VALUE_BITS + 4 - ND_4 * 4;
    localparam int PAD_5 = VALUE_BITS + 4 - ND_5 * 5;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ERR   = 4'b0010,
        S_SIGN  = 4'b0100,
        S_DIGIT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_started, n_started;

    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_rad_ok;
    logic [CW-1:0]         w_nd;
    logic [2:0]            w_pad;
    logic [DIGIT_W-1:0]    w_digit;
    logic                  w_free;
    logic                  w_push;
    t_result               w_res;
    t_shift_ctl            w_ctl;

    assign w_neg    = i_in.value[VALUE_BITS-1];
    assign w_mag    = w_neg ? (~i_in.value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : i_in.value;
    assign w_rad_ok = (i_in.radix_bits >= RADIX_MIN) && (i_in.radix_bits <= RADIX_MAX);

    always_comb begin
        unique case (i_in.radix_bits)
            3'd1: begin
                w_nd  = CW'(ND_1);
                w_pad = 3'(PAD_1);
            end
            3'd2: begin
                w_nd  = CW'(ND_2);
                w_pad = 3'(PAD_2);
            end
            3'd3: begin
                w_nd  = CW'(ND_3);
                w_pad = 3'(PAD_3);
            end
            3'd4: begin
                w_nd  = CW'(ND_4);
                w_pad = 3'(PAD_4);
            end
            3'd5: begin
                w_nd  = CW'(ND_5);
                w_pad = 3'(PAD_5);
            end
            default: begin
                w_nd  = CW'(1);
                w_pad = 3'd0;
            end
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_started = r_started;
        w_ctl     = '0;
        w_push    = 1'b0;
        w_res     = '{out_char: CHAR_NUL, status: ST_OK, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    w_ctl.load = 1'b1;
                    n_cnt      = w_nd;
                    n_started  = 1'b0;
                    if (!w_rad_ok) begin
                        n_state = S_ERR;
                    end else if (w_neg) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_ERR: begin
                w_res = '{out_char: CHAR_NUL, status: ST_BAD_RADIX, last: 1'b1};
                if (w_free) begin
                    w_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SIGN: begin
                w_res = '{out_char: CHAR_MINUS, status: ST_OK, last: 1'b0};
                if (w_free) begin
                    w_push  = 1'b1;
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                w_res = '{out_char: digit_char(w_digit), status: ST_OK,
                          last: (r_cnt == CW'(1))};
                // leading zero: drop it, but always keep the final digit
                if ((w_digit == '0) && !r_started && (r_cnt != CW'(1))) begin
                    w_ctl.shift = 1'b1;
                    n_cnt       = r_cnt - CW'(1);
                end else if (w_free) begin
                    w_push      = 1'b1;
                    w_ctl.shift = 1'b1;
                    n_cnt       = r_cnt - CW'(1);
                    n_started   = 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_started <= n_started;
        end
    end

    i2pr_shift_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) u_shift (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_mag   (w_mag),
        .i_pad   (w_pad),
        .i_radix (i_in.radix_bits),
        .o_digit (w_digit)
    );

    i2pr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_free  (w_free),
        .o_out   (o_out)
    );

    `I2PR_ASSERT(a_state_onehot, ($onehot(r_state)), "sequencer state not one-hot")
    `I2PR_ASSERT(a_push_free, (w_push |-> w_free), "result pushed into occupied slot")
    `I2PR_ASSERT(a_cnt_live, ((r_state == S_DIGIT) |-> (r_cnt != '0)), "digit count ran out")
    `I2PR_ASSERT_NEXT(a_last_idle, w_push && w_res.last, r_state == S_IDLE, "no idle after last")

endmodule

`default_nettype wire

// ===== dv/int_to_pow2_radix_ascii_unit_tb.sv =====
// Testbench for int_to_pow2_radix_ascii_unit: predicts the ASCII characters of each conversion
// and checks every output transfer against them, under directed, random and backpressure traffic.
// Depends on i2pr_pkg, i2pr_if and the int_to_pow2_radix_ascii_unit RTL.
`timescale 1ns / 1ps

module int_to_pow2_radix_ascii_unit_tb;
    import i2pr_pkg::*;

    localparam int     VALUE_BITS   = 32;
    localparam int     CLK_PERIOD   = 10;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     MAX_REPORTS  = 10;
    localparam longint TIMEOUT_NS   = 64'd5_000_000;

    logic i_clk;
    logic i_rst_n;

    i2pr_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
    i2pr_out_if                           out_ch ();

    int_to_pow2_radix_ascii_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_result expected_chars[$];
    int      mismatch_count = 0;
    int      src_idle_pct   = 0;
    int      sink_stall_pct = 0;
    int      holdoff_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("int_to_pow2_radix_ascii_unit_tb NOT OK");
        $finish;
    end

    // Sink ready: a long holdoff when requested, random stalls otherwise.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                out_ch.ready = 1'b0;
                holdoff_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    function automatic void predict_conversion(input logic [VALUE_BITS-1:0] v,
                                               input logic [2:0] r);
        string                 digit_set;
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] digit_mask;
        logic [6:0]            digits[$];
        digit_set = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
        if (r < RADIX_MIN || r > RADIX_MAX) begin
            expected_chars.push_back('{CHAR_NUL, ST_BAD_RADIX, 1'b1});
            return;
        end
        if (v == '0) begin
            expected_chars.push_back('{CHAR_ZERO, ST_OK, 1'b1});
            return;
        end
        if (v[VALUE_BITS-1]) begin
            expected_chars.push_back('{CHAR_MINUS, ST_OK, 1'b0});
        end
        // unsigned magnitude, so the most negative value converts as 2^(N-1)
        mag = v[VALUE_BITS-1] ? -v : v;
        digit_mask = (32'd1 << r) - 32'd1;
        while (mag != '0) begin
            digits.push_front(7'(digit_set[int'(mag & digit_mask)]));
            mag = mag >> r;
        end
        foreach (digits[i]) begin
            expected_chars.push_back('{digits[i], ST_OK, (i == digits.size() - 1)});
        end
    endfunction

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected char=%h status=%b last=%b, got char=%h status=%b last=%b",
                     $realtime, what, want.out_char, want.status, want.last,
                     got.out_char, got.status, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.out_char, out_ch.status, out_ch.last};
            if (expected_chars.size() == 0) begin
                note_mismatch("unexpected transfer", '0, got);
            end else begin
                want = expected_chars.pop_front();
                if (got.out_char !== want.out_char || got.status !== want.status ||
                    got.last !== want.last) begin
                    note_mismatch("char mismatch", want, got);
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_conversion(input logic [VALUE_BITS-1:0] v, input logic [2:0] r);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.value      = v;
        in_ch.radix_bits = r;
        in_ch.valid      = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_conversion(v, r);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_all_chars();
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return $urandom_range(40);
            2:       return 32'(0 - $urandom_range(40));
            3:       return 32'h8000_0000 + $urandom_range(3);
            4:       return 32'h7FFF_FFFF - $urandom_range(3);
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [2:0] pick_radix();
        int bad;
        if ($urandom_range(99) < 15) begin
            bad = $urandom_range(2);
            return (bad == 0) ? 3'd0 : 3'(bad + 5);
        end
        return 3'($urandom_range(RADIX_MAX, RADIX_MIN));
    endfunction

    task automatic random_items(input int n);
        repeat (n) send_conversion(pick_value(), pick_radix());
        wait_all_chars();
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int r = RADIX_MIN; r <= RADIX_MAX; r++) begin
            send_conversion('0, 3'(r));
        end
        send_conversion(32'h8000_0000, 3'd1);
        send_conversion(32'h8000_0000, 3'd3);
        send_conversion(32'h8000_0000, 3'd5);
        send_conversion(32'h7FFF_FFFF, 3'd1);
        send_conversion(32'h7FFF_FFFF, 3'd5);
        send_conversion(32'hFFFF_FFFF, 3'd1);
        send_conversion(32'h0000_0001, 3'd5);
        send_conversion(32'h0123_4567, 3'd4);
        send_conversion(32'h89AB_CDEF, 3'd4);
        send_conversion(32'h0765_4321, 3'd3);
        send_conversion(32'h3E4C_A86A, 3'd5);
        send_conversion(32'h1AC6_88FA, 3'd5);
        send_conversion(32'h0000_0002, 3'd2);
        send_conversion('0, 3'd0);
        send_conversion(32'h0000_0005, 3'd6);
        send_conversion(32'hFFFF_FFFF, 3'd7);
        send_conversion(32'h8000_0000, 3'd0);
        send_conversion(32'h7FFF_FFFF, 3'd6);
        wait_all_chars();
    endtask

    task automatic test_no_idling();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        random_items(60);
    endtask

    task automatic test_sender_gaps();
        src_idle_pct   = 68;
        sink_stall_pct = 0;
        random_items(45);
    endtask

    task automatic test_receiver_stalls();
        src_idle_pct   = 0;
        sink_stall_pct = 68;
        random_items(45);
    endtask

    task automatic test_both_idle();
        src_idle_pct   = 23;
        sink_stall_pct = 23;
        random_items(45);
    endtask

    task automatic test_output_holdoff();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        holdoff_left   = 400;
        random_items(30);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.radix_bits = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_output_holdoff();

        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("int_to_pow2_radix_ascii_unit_tb OK");
        end else begin
            $display("int_to_pow2_radix_ascii_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
